/* sv/lsfl_pkg.sv */
`default_nettype none

package lsfl_pkg;

   // Field widths fixed by the request and result formats.
   localparam int ENTRY_W  = 10;
   localparam int BYTE_W   = 8;
   localparam int STEP_W   = 16;
   localparam int SEQ_W    = 26;
   localparam int SUM_W    = 16;

   localparam int DEFAULT_STEP_DEPTH     = 1024;
   localparam int DEFAULT_SEQUENCE_DEPTH = 256;

   typedef enum logic [1:0] {
      ACT_WRITE_STEP,
      ACT_WRITE_SEQ,
      ACT_FRAME_AT_AGE,
      ACT_FRAME_AT_STEP
   } action_type;

   typedef struct packed {
      action_type               action;
      logic [ENTRY_W-1:0]       entry_index;
      logic [BYTE_W-1:0]        step_duration;
      logic [BYTE_W-1:0]        step_frame;
      logic [ENTRY_W-1:0]       seq_first_step;
      logic [BYTE_W-1:0]        seq_step_count;
      logic [BYTE_W-1:0]        seq_loop_step;
      logic [BYTE_W-1:0]        group_size;
      logic [BYTE_W-1:0]        selector;
      logic                     zero_group_as_one;
      logic [BYTE_W-1:0]        age;
      logic [BYTE_W-1:0]        step_number;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame;
      logic [BYTE_W-1:0] step_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MOD,
      S_WR_STEP,
      S_WR_SEQ,
      S_SEQ_SUM,
      S_SEQ_READ,
      S_SEQ_WAIT,
      S_BASE,
      S_STEP_READ,
      S_STEP_WAIT,
      S_SUM,
      S_AGE_WRAP,
      S_AGE_ADD,
      S_FIND
   } state_type;

endpackage

`default_nettype wire

/* sv/looping_sprite_frame_lookup_top.sv */
`default_nettype none

// Looping sprite frame lookup.
// A request is taken at a rising edge where start is high and busy is low; busy
// then stays high until done, save as noted below. Requests either fill the step
// store (duration, frame) or the sequence table (first step, count, loop step),
// or query a frame from a sequence chosen as entry_index plus selector modulo
// group_size. Writes give no result. Each query gives exactly one result on
// rsp_data, shown for one cycle with rsp_strobe high; the receiver cannot hold
// it off, and busy drops in the same cycle the strobe rises.
// All remainders come from one remainder unit that retires one numerator bit
// per cycle. A step query takes four remainders. An age query reads the step
// store in two walks across the sequence, one step per cycle through the
// single read port; the second walk stops at the step that holds the age.
// Empty group, zero_group_as_one low: busy stays low, answer in the next cycle.
// Reset returns the sequencer to idle and clears the strobe; the store
// contents are kept and count as undefined until written.
module looping_sprite_frame_lookup_top #(
   parameter int STEP_DEPTH     = lsfl_pkg::DEFAULT_STEP_DEPTH,
   parameter int SEQUENCE_DEPTH = lsfl_pkg::DEFAULT_SEQUENCE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire lsfl_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output lsfl_pkg::rsp_type      rsp_data
);

   localparam int STEP_AW  = $clog2(STEP_DEPTH);
   localparam int SEQ_AW   = $clog2(SEQUENCE_DEPTH);
   // The numerator must hold a store address plus an 8-bit offset.
   localparam int NUM_W    = (STEP_AW + 1 > 11) ? STEP_AW + 1 : 11;
   localparam int STEP_DW  = $clog2(STEP_DEPTH + 1);
   localparam int SEQ_DW   = $clog2(SEQUENCE_DEPTH + 1);
   localparam int DEPTH_W  = (STEP_DW > SEQ_DW) ? STEP_DW : SEQ_DW;
   localparam int DIV_W    = (DEPTH_W > lsfl_pkg::SUM_W) ? DEPTH_W : lsfl_pkg::SUM_W;
   localparam int CNT_W    = $clog2(NUM_W);
   localparam int BW       = lsfl_pkg::BYTE_W;
   localparam int SW       = lsfl_pkg::SUM_W;

   // Sequencer and remainder unit state.
   lsfl_pkg::state_type state_ff, state_in;
   lsfl_pkg::state_type mod_ret_ff, mod_ret_in;
   logic [NUM_W-1:0]    mod_num_ff, mod_num_in;
   logic [DIV_W-1:0]    mod_div_ff, mod_div_in;
   logic [DIV_W-1:0]    mod_rem_ff, mod_rem_in;
   logic [CNT_W-1:0]    mod_cnt_ff, mod_cnt_in;

   // Request and sequence context.
   lsfl_pkg::req_type   req_ff, req_in;
   logic [BW-1:0]       count_ff, count_in;
   logic [BW-1:0]       loop_ff, loop_in;
   logic [STEP_AW-1:0]  base_ff, base_in;

   // Step walk state.
   logic [STEP_AW-1:0]  addr_ff, addr_in;
   logic [BW-1:0]       iss_ff, iss_in;
   logic [BW-1:0]       acc_ff, acc_in;
   logic                rvalid_ff, rvalid_in;
   logic [SW-1:0]       prefix_ff, prefix_in;
   logic [SW-1:0]       total_ff, total_in;
   logic [SW-1:0]       cursor_ff, cursor_in;

   // Result register.
   lsfl_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   // Combinational helpers.
   logic                mod_go;
   logic [NUM_W-1:0]    mod_go_num;
   logic [DIV_W-1:0]    mod_go_div;
   lsfl_pkg::state_type mod_go_ret;
   logic                walk_go;
   logic [DIV_W:0]      mod_shift;
   logic [DIV_W:0]      mod_diff;
   logic                mod_ge;
   logic [BW-1:0]       group_eff;
   logic [BW-1:0]       last_step;
   logic [BW-1:0]       step_sel;
   logic [BW-1:0]       step_dur;
   logic                issue;
   logic [STEP_AW-1:0]  addr_next;
   logic [SW-1:0]       age_wide;
   logic [SW-1:0]       age_diff;
   logic [SW-1:0]       span;

   // Memory ports.
   logic                step_wr_en;
   logic [STEP_AW-1:0]  step_rd_addr;
   logic [lsfl_pkg::STEP_W-1:0] step_wr_data;
   logic [lsfl_pkg::STEP_W-1:0] step_rd_data;
   logic                seq_wr_en;
   logic [lsfl_pkg::SEQ_W-1:0]  seq_wr_data;
   logic [lsfl_pkg::SEQ_W-1:0]  seq_rd_data;

   lsfl_ram #(
      .WIDTH (lsfl_pkg::STEP_W),
      .DEPTH (STEP_DEPTH)
   ) u_step_ram (
      .clock   (clock),
      .wr_en   (step_wr_en),
      .wr_addr (mod_rem_ff[STEP_AW-1:0]),
      .wr_data (step_wr_data),
      .rd_addr (step_rd_addr),
      .rd_data (step_rd_data)
   );

   lsfl_ram #(
      .WIDTH (lsfl_pkg::SEQ_W),
      .DEPTH (SEQUENCE_DEPTH)
   ) u_seq_ram (
      .clock   (clock),
      .wr_en   (seq_wr_en),
      .wr_addr (mod_rem_ff[SEQ_AW-1:0]),
      .wr_data (seq_wr_data),
      .rd_addr (mod_rem_ff[SEQ_AW-1:0]),
      .rd_data (seq_rd_data)
   );

   assign step_wr_data = {req_ff.step_duration, req_ff.step_frame};
   assign seq_wr_data  = {req_ff.seq_first_step, req_ff.seq_step_count,
                          req_ff.seq_loop_step};

   // Shared restoring remainder step: shift in one numerator bit, subtract
   // the divisor when it fits.
   assign mod_shift = {mod_rem_ff, mod_num_ff[NUM_W-1]};
   assign mod_diff  = mod_shift - {1'b0, mod_div_ff};
   assign mod_ge    = (mod_shift >= {1'b0, mod_div_ff});

   assign group_eff = (req_ff.group_size == '0) ? BW'(1) : req_ff.group_size;
   assign last_step = count_ff - BW'(1);
   assign step_sel  = (req_ff.step_number > last_step) ? last_step : req_ff.step_number;
   assign step_dur  = (step_rd_data[15:8] == '0) ? BW'(1) : step_rd_data[15:8];
   assign issue     = (iss_ff != count_ff);
   assign addr_next = (addr_ff == STEP_AW'(STEP_DEPTH - 1)) ? '0 : addr_ff + 1'b1;
   assign age_wide  = SW'(req_ff.age);
   assign age_diff  = age_wide - prefix_ff;
   assign span      = total_ff - prefix_ff;

   always_comb begin
      state_in      = state_ff;
      mod_ret_in    = mod_ret_ff;
      mod_num_in    = mod_num_ff;
      mod_div_in    = mod_div_ff;
      mod_rem_in    = mod_rem_ff;
      mod_cnt_in    = mod_cnt_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      loop_in       = loop_ff;
      base_in       = base_ff;
      addr_in       = addr_ff;
      iss_in        = iss_ff;
      acc_in        = acc_ff;
      rvalid_in     = 1'b0;
      prefix_in     = prefix_ff;
      total_in      = total_ff;
      cursor_in     = cursor_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      mod_go        = 1'b0;
      mod_go_num    = '0;
      mod_go_div    = DIV_W'(1);
      mod_go_ret    = lsfl_pkg::S_IDLE;
      walk_go       = 1'b0;
      step_wr_en    = 1'b0;
      seq_wr_en     = 1'b0;
      step_rd_addr  = addr_ff;

      case (state_ff)
         lsfl_pkg::S_IDLE: begin
            if (start) begin
               req_in = req_data;
               case (req_data.action)
                  lsfl_pkg::ACT_WRITE_STEP: begin
                     mod_go     = 1'b1;
                     mod_go_num = NUM_W'(req_data.entry_index);
                     mod_go_div = DIV_W'(STEP_DEPTH);
                     mod_go_ret = lsfl_pkg::S_WR_STEP;
                  end
                  lsfl_pkg::ACT_WRITE_SEQ: begin
                     mod_go     = 1'b1;
                     mod_go_num = NUM_W'(req_data.entry_index);
                     mod_go_div = DIV_W'(SEQUENCE_DEPTH);
                     mod_go_ret = lsfl_pkg::S_WR_SEQ;
                  end
                  default: begin
                     if (req_data.group_size == '0 && !req_data.zero_group_as_one) begin
                        rsp_in        = '0;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        mod_go     = 1'b1;
                        mod_go_num = NUM_W'(req_data.selector);
                        mod_go_div = (req_data.group_size == '0) ? DIV_W'(1)
                                                                 : DIV_W'(req_data.group_size);
                        mod_go_ret = lsfl_pkg::S_SEQ_SUM;
                     end
                  end
               endcase
            end
         end
         lsfl_pkg::S_MOD: begin
            mod_rem_in = mod_ge ? mod_diff[DIV_W-1:0] : mod_shift[DIV_W-1:0];
            mod_num_in = mod_num_ff << 1;
            mod_cnt_in = mod_cnt_ff + 1'b1;
            if (mod_cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = mod_ret_ff;
            end
         end
         lsfl_pkg::S_WR_STEP: begin
            step_wr_en = 1'b1;
            state_in   = lsfl_pkg::S_IDLE;
         end
         lsfl_pkg::S_WR_SEQ: begin
            seq_wr_en = 1'b1;
            state_in  = lsfl_pkg::S_IDLE;
         end
         lsfl_pkg::S_SEQ_SUM: begin
            // The selector offset is below the group size, so it fits a byte.
            mod_go     = 1'b1;
            mod_go_num = NUM_W'(req_ff.entry_index) + NUM_W'(mod_rem_ff[BW-1:0]);
            mod_go_div = DIV_W'(SEQUENCE_DEPTH);
            mod_go_ret = lsfl_pkg::S_SEQ_READ;
         end
         lsfl_pkg::S_SEQ_READ: begin
            state_in = lsfl_pkg::S_SEQ_WAIT;
         end
         lsfl_pkg::S_SEQ_WAIT: begin
            count_in = seq_rd_data[15:8];
            loop_in  = seq_rd_data[7:0];
            if (seq_rd_data[15:8] == '0) begin
               rsp_in        = '0;
               rsp_strobe_in = 1'b1;
               state_in      = lsfl_pkg::S_IDLE;
            end else begin
               mod_go     = 1'b1;
               mod_go_num = NUM_W'(seq_rd_data[25:16]);
               mod_go_div = DIV_W'(STEP_DEPTH);
               mod_go_ret = lsfl_pkg::S_BASE;
            end
         end
         lsfl_pkg::S_BASE: begin
            base_in = mod_rem_ff[STEP_AW-1:0];
            if (req_ff.action == lsfl_pkg::ACT_FRAME_AT_STEP) begin
               mod_go     = 1'b1;
               mod_go_num = NUM_W'(mod_rem_ff[STEP_AW-1:0]) + NUM_W'(step_sel);
               mod_go_div = DIV_W'(STEP_DEPTH);
               mod_go_ret = lsfl_pkg::S_STEP_READ;
            end else begin
               addr_in   = mod_rem_ff[STEP_AW-1:0];
               iss_in    = '0;
               acc_in    = '0;
               prefix_in = '0;
               total_in  = '0;
               state_in  = lsfl_pkg::S_SUM;
            end
         end
         lsfl_pkg::S_STEP_READ: begin
            step_rd_addr = mod_rem_ff[STEP_AW-1:0];
            state_in     = lsfl_pkg::S_STEP_WAIT;
         end
         lsfl_pkg::S_STEP_WAIT: begin
            rsp_in.frame      = step_rd_data[7:0];
            rsp_in.step_count = count_ff;
            rsp_strobe_in     = 1'b1;
            state_in          = lsfl_pkg::S_IDLE;
         end
         lsfl_pkg::S_SUM: begin
            // One read issued per cycle; its data is summed in the next cycle.
            if (issue) begin
               iss_in    = iss_ff + 1'b1;
               addr_in   = addr_next;
               rvalid_in = 1'b1;
            end
            if (rvalid_ff) begin
               if (acc_ff < loop_ff) begin
                  prefix_in = prefix_ff + SW'(step_dur);
               end
               total_in = total_ff + SW'(step_dur);
               acc_in   = acc_ff + 1'b1;
               if (acc_ff == last_step) begin
                  state_in = lsfl_pkg::S_AGE_WRAP;
               end
            end
         end
         lsfl_pkg::S_AGE_WRAP: begin
            if (loop_ff < count_ff && age_wide >= prefix_ff) begin
               if (span != '0) begin
                  // The age past the loop start is below 256.
                  mod_go     = 1'b1;
                  mod_go_num = NUM_W'(age_diff[BW-1:0]);
                  mod_go_div = DIV_W'(span);
                  mod_go_ret = lsfl_pkg::S_AGE_ADD;
               end else begin
                  cursor_in = age_wide;
                  walk_go   = 1'b1;
               end
            end else if (age_wide >= total_ff) begin
               cursor_in = total_ff - SW'(1);
               walk_go   = 1'b1;
            end else begin
               cursor_in = age_wide;
               walk_go   = 1'b1;
            end
         end
         lsfl_pkg::S_AGE_ADD: begin
            cursor_in = prefix_ff + mod_rem_ff[SW-1:0];
            walk_go   = 1'b1;
         end
         lsfl_pkg::S_FIND: begin
            if (issue) begin
               iss_in    = iss_ff + 1'b1;
               addr_in   = addr_next;
               rvalid_in = 1'b1;
            end
            if (rvalid_ff) begin
               // The last step answers whatever is left of the cursor.
               if (cursor_ff < SW'(step_dur) || acc_ff == last_step) begin
                  rsp_in.frame      = step_rd_data[7:0];
                  rsp_in.step_count = count_ff;
                  rsp_strobe_in     = 1'b1;
                  rvalid_in         = 1'b0;
                  state_in          = lsfl_pkg::S_IDLE;
               end else begin
                  cursor_in = cursor_ff - SW'(step_dur);
                  acc_in    = acc_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = lsfl_pkg::S_IDLE;
         end
      endcase

      if (mod_go) begin
         mod_num_in = mod_go_num;
         mod_div_in = mod_go_div;
         mod_rem_in = '0;
         mod_cnt_in = '0;
         mod_ret_in = mod_go_ret;
         state_in   = lsfl_pkg::S_MOD;
      end

      if (walk_go) begin
         addr_in  = base_ff;
         iss_in   = '0;
         acc_in   = '0;
         state_in = lsfl_pkg::S_FIND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lsfl_pkg::S_IDLE;
         rvalid_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rvalid_ff     <= rvalid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mod_ret_ff <= mod_ret_in;
      mod_num_ff <= mod_num_in;
      mod_div_ff <= mod_div_in;
      mod_rem_ff <= mod_rem_in;
      mod_cnt_ff <= mod_cnt_in;
      req_ff     <= req_in;
      count_ff   <= count_in;
      loop_ff    <= loop_in;
      base_ff    <= base_in;
      addr_ff    <= addr_in;
      iss_ff     <= iss_in;
      acc_ff     <= acc_in;
      prefix_ff  <= prefix_in;
      total_ff   <= total_in;
      cursor_ff  <= cursor_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != lsfl_pkg::S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTH
   // A result always finishes its request, so the block is idle under the strobe.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !busy)
      else $error("result strobe while a request is still in progress");

   // A result only ends work that was under way or a request just taken.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(busy || start))
      else $error("result strobe without a request in progress");

   // The remainder unit never runs with a zero divisor.
   a_mod_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsfl_pkg::S_MOD) |-> (mod_div_ff != '0))
      else $error("remainder unit started with zero divisor");

   // The step walks never issue more reads than the sequence has steps.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsfl_pkg::S_SUM || state_ff == lsfl_pkg::S_FIND) |->
         (iss_ff <= count_ff))
      else $error("step walk ran past the end of the sequence");
`endif

endmodule

`default_nettype wire

/* sv/lsfl_ram.sv */
`default_nettype none

// Single-port-write, single-port-read RAM with a registered read.
module lsfl_ram #(
   parameter int WIDTH = lsfl_pkg::STEP_W,
   parameter int DEPTH = lsfl_pkg::DEFAULT_STEP_DEPTH,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
